// ===== src/eto_pkg.sv =====
// Shared types, widths and constants of the enveloped tone oscillator.
// Holds the quarter-sine entry function used to build the table at elaboration.
// No dependencies.
package eto_pkg;

  typedef longint unsigned u64_t;

  // Field widths fixed by the register and port definitions.
  localparam int WAVE_SEL_W = 2;
  localparam int STEP_W     = 32;
  localparam int AMP_W      = 15;
  localparam int LEN_W      = 21;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;

  // Shape magnitude is 0..32768 in units of 1/32768.
  localparam int WAVE_MAG_W = 16;
  localparam logic [WAVE_MAG_W-1:0] WAVE_ONE = 16'h8000;

  // Envelope is 0..65536 in units of 1/65536.
  localparam int ENV_FRAC_W = 16;
  localparam int ENV_W      = ENV_FRAC_W + 1;
  localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

  // Serial multiplier: amplitude * shape, then that product * envelope.
  localparam int MUL_A_W   = AMP_W + WAVE_MAG_W;
  localparam int MUL_P_W   = MUL_A_W + ENV_W;
  localparam int MAG_SHIFT = 31;
  localparam int MAG_W     = MUL_P_W - MAG_SHIFT;

  localparam u64_t HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [WAVE_SEL_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_SHAPE    = 3'd0,
    CFG_PHASE_STEP    = 3'd1,
    CFG_AMPLITUDE     = 3'd2,
    CFG_NOTE_LENGTH   = 3'd3,
    CFG_ATTACK_LENGTH = 3'd4,
    CFG_RELEASE_POINT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                  neg;
    logic [WAVE_MAG_W-1:0] mag;
  } shape_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [ENV_W-1:0]   b;
  } mul_req_t;

  // One Q30 Taylor term step: t * a^2.
  function automatic u64_t sine_term(u64_t t, u64_t a);
    return (((t * a) >> 30) * a) >> 30;
  endfunction

  // Quarter-wave entry k of a table with 2^dlog steps, in units of 1/32768.
  function automatic logic [WAVE_MAG_W-1:0] sine_entry(int unsigned k, int unsigned dlog);
    u64_t a;
    u64_t sum;
    u64_t t;
    u64_t v;
    a   = (u64_t'(k) * HALF_PI_Q30) >> dlog;
    sum = a;
    t   = a;
    t   = sine_term(t, a) / 64'd6;
    sum = sum - t;
    t   = sine_term(t, a) / 64'd20;
    sum = sum + t;
    t   = sine_term(t, a) / 64'd42;
    sum = sum - t;
    t   = sine_term(t, a) / 64'd72;
    sum = sum + t;
    t   = sine_term(t, a) / 64'd110;
    sum = sum - t;
    t   = sine_term(t, a) / 64'd156;
    sum = sum + t;
    v   = (sum + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return WAVE_MAG_W'(v);
  endfunction

endpackage

// ===== src/eto_shape.sv =====
// Waveform stage: turns a phase into a signed shape value (sign and magnitude).
// Sine uses a constant quarter-wave table built at elaboration.
// Depends on eto_pkg.
module eto_shape #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic [eto_pkg::WAVE_SEL_W-1:0]  wave_shape_i,
  input  logic [PHASE_BITS-1:0]           phase_i,
  output eto_pkg::shape_t                 shape_o
);

  localparam int DEPTH_LOG = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam int DEPTH     = 1 << DEPTH_LOG;
  localparam int MW        = eto_pkg::WAVE_MAG_W;

  localparam logic [MW-1:0] SINE_PEAK = eto_pkg::sine_entry(DEPTH, DEPTH_LOG);
  localparam logic [PHASE_BITS-1:0] HALF    = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  logic [MW-1:0] sine_lut [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_lut
    assign sine_lut[k] = eto_pkg::sine_entry(k, DEPTH_LOG);
  end

  logic [1:0]            quad;
  logic [DEPTH_LOG-1:0]  sidx;
  logic [DEPTH_LOG-1:0]  raddr;
  logic [PHASE_BITS-1:0] tri_f;
  logic [PHASE_BITS-1:0] tri_dist;
  logic [PHASE_BITS:0]   tri_dist_x;
  logic [MW:0]           tri_s;
  logic [MW-1:0]         saw_u;
  eto_pkg::shape_t       shape_d;
  eto_pkg::shape_t       shape_q;

  always_comb begin
    quad  = phase_i[PHASE_BITS-1:PHASE_BITS-2];
    sidx  = phase_i[PHASE_BITS-3 -: DEPTH_LOG];
    // Falling quadrants read the table mirrored; index zero mirrors onto the peak.
    raddr = quad[0] ? -sidx : sidx;

    tri_f      = phase_i - QUARTER;
    tri_dist   = tri_f[PHASE_BITS-1] ? -tri_f : tri_f;
    tri_dist_x = {tri_dist, 1'b0};
    tri_s      = (MW + 1)'(tri_dist_x >> (PHASE_BITS - 16));

    saw_u = phase_i[PHASE_BITS-1 -: MW];

    unique case (eto_pkg::wave_e'(wave_shape_i))
      eto_pkg::WAVE_SINE: begin
        shape_d.neg = quad[1];
        shape_d.mag = (quad[0] && (sidx == '0)) ? SINE_PEAK : sine_lut[raddr];
      end
      eto_pkg::WAVE_SQUARE: begin
        shape_d.neg = phase_i[PHASE_BITS-1];
        shape_d.mag = ((phase_i == '0) || (phase_i == HALF)) ? '0 : eto_pkg::WAVE_ONE;
      end
      eto_pkg::WAVE_TRIANGLE: begin
        if (tri_s <= {1'b0, eto_pkg::WAVE_ONE}) begin
          shape_d.neg = 1'b0;
          shape_d.mag = MW'({1'b0, eto_pkg::WAVE_ONE} - tri_s);
        end else begin
          shape_d.neg = 1'b1;
          shape_d.mag = MW'(tri_s - {1'b0, eto_pkg::WAVE_ONE});
        end
      end
      eto_pkg::WAVE_SAW: begin
        shape_d.neg = saw_u[MW-1];
        shape_d.mag = saw_u[MW-1] ? -saw_u : saw_u;
      end
      default: begin
        shape_d.neg = 1'b0;
        shape_d.mag = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shape_q <= shape_d;
    end
  end

  assign shape_o = shape_q;

endmodule

// ===== src/eto_div.sv =====
// Restoring divider for the envelope fraction: quot = num * 2^16 / den.
// One quotient bit per cycle; requires num < den. Depends on eto_pkg.
module eto_div #(
  parameter int W = 21
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [W-1:0]                     num_i,
  input  logic [W-1:0]                     den_i,
  output logic                             done_o,
  output logic [eto_pkg::ENV_FRAC_W-1:0]   quot_o
);

  localparam int QW = eto_pkg::ENV_FRAC_W;
  localparam int CW = $clog2(QW + 1);

  logic [W-1:0]  rem_q;
  logic [W-1:0]  den_q;
  logic [QW-1:0] quot_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [W:0] rem_sh;
  logic       ge;
  logic [W:0] rem_nx;

  // The remainder stays below den, so it always fits in W bits.
  always_comb begin
    rem_sh = {rem_q, 1'b0};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_nx[W-1:0];
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/eto_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Shared by both scaling passes of a sample. Depends on eto_pkg.
module eto_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eto_pkg::mul_req_t             req_i,
  output logic                          done_o,
  output logic [eto_pkg::MUL_P_W-1:0]   prod_o
);

  localparam int AW = eto_pkg::MUL_A_W;
  localparam int BW = eto_pkg::ENV_W;
  localparam int PW = eto_pkg::MUL_P_W;
  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] mc_q;
  logic [BW-1:0] ml_q;
  logic [PW-1:0] acc_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [PW-1:0] acc_nx;

  assign acc_nx = {acc_q[PW-2:0], 1'b0} + (ml_q[BW-1] ? PW'(mc_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The product holds after completion until the next start.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mc_q  <= req_i.a;
      ml_q  <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_nx;
      ml_q  <= {ml_q[BW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== src/enveloped_tone_oscillator_top.sv =====
// Top level of the enveloped tone oscillator: configuration, note sequencing,
// envelope and scaling control. Depends on eto_pkg, eto_shape, eto_div, eto_mul.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   restart_i
//   result   out        out_valid_o / out_stall_i sample_o, last_o
//   config   in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// When the envelope divides, a sample passes through the serial divider and then
// two passes of the serial multiplier; when the envelope is flat or zero, the
// divider is skipped and only the two multiplier passes remain.
// A tick with no note playing is taken without leaving idle and gives no result.
// Reset leaves the block idle with registers at their reset values.
// A held result does not block the next transfer; a finished sample waits
// only if the previous one is still stalled at the output.
module enveloped_tone_oscillator_top #(
  parameter int PHASE_BITS       = 32,
  parameter int COUNT_BITS       = 21,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  sample_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [eto_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eto_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int LW = (COUNT_BITS > eto_pkg::LEN_W) ? COUNT_BITS : eto_pkg::LEN_W;
  localparam logic [LW-1:0] LEN_MAX = LW'(1) << (COUNT_BITS - 1);
  localparam int MW = (SAMPLE_BITS > eto_pkg::MAG_W) ? SAMPLE_BITS : eto_pkg::MAG_W;
  localparam logic [MW-1:0] MAG_LIM = (MW'(1) << (SAMPLE_BITS - 1)) - MW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_WAIT_DIV,
    ST_MUL_AW,
    ST_MUL_ENV,
    ST_SEND
  } state_e;

  // Configuration registers.
  logic [eto_pkg::WAVE_SEL_W-1:0] wave_shape_q;
  logic [eto_pkg::STEP_W-1:0]     phase_step_q;
  logic [eto_pkg::AMP_W-1:0]      amplitude_q;
  logic [eto_pkg::LEN_W-1:0]      note_length_q;
  logic [eto_pkg::LEN_W-1:0]      attack_length_q;
  logic [eto_pkg::LEN_W-1:0]      release_point_q;

  state_e                  state_q;
  logic [PHASE_BITS-1:0]   phase_q;
  logic [COUNT_BITS-1:0]   idx_q;
  logic                    playing_q;
  logic                    env_div_q;
  logic                    out_valid_q;
  logic [eto_pkg::ENV_W-1:0] env_q;
  logic                    last_q;
  logic [SAMPLE_BITS-1:0]  sample_q;
  logic                    out_last_q;

  // Per-sample envelope decisions.
  logic [LW-1:0]         len_w, rel_w, att_w;
  logic [LW-1:0]         len_c, rel_c, att_c;
  logic [COUNT_BITS-1:0] len_n, rel_n, att_n;
  logic [COUNT_BITS-1:0] rel_num, rel_den;
  logic [COUNT_BITS-1:0] div_num, div_den;
  logic [COUNT_BITS:0]   idx_inc;
  logic                  env_div;
  logic [eto_pkg::ENV_W-1:0] env_fix;
  logic                  last;

  logic                  in_xfer;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic [eto_pkg::ENV_FRAC_W-1:0] div_quot;
  eto_pkg::mul_req_t     mul_req;
  logic                  mul_done;
  logic [eto_pkg::MUL_P_W-1:0] mul_prod;
  eto_pkg::shape_t       shape;
  logic [MW-1:0]         mag_ext;
  logic [MW-1:0]         mag_sat;
  logic [SAMPLE_BITS-1:0] res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Lengths are clamped: note length to 1..LEN_MAX, release to the note
  // length and attack to the release point.
  always_comb begin
    len_w = LW'(note_length_q);
    rel_w = LW'(release_point_q);
    att_w = LW'(attack_length_q);
    if (len_w == '0) begin
      len_c = LW'(1);
    end else if (len_w > LEN_MAX) begin
      len_c = LEN_MAX;
    end else begin
      len_c = len_w;
    end
    rel_c = (rel_w < len_c) ? rel_w : len_c;
    att_c = (att_w < rel_c) ? att_w : rel_c;
    len_n = COUNT_BITS'(len_c);
    rel_n = COUNT_BITS'(rel_c);
    att_n = COUNT_BITS'(att_c);

    rel_num = (len_n > idx_q) ? (len_n - idx_q - COUNT_BITS'(1)) : '0;
    rel_den = len_n - rel_n;

    env_div = 1'b0;
    env_fix = eto_pkg::ENV_ONE;
    div_num = idx_q;
    div_den = att_n;
    if (idx_q >= rel_n) begin
      if (rel_den == '0) begin
        env_fix = '0;
      end else begin
        env_div = 1'b1;
        div_num = rel_num;
        div_den = rel_den;
      end
    end else if (idx_q < att_n) begin
      env_div = 1'b1;
    end

    idx_inc = {1'b0, idx_q} + (COUNT_BITS + 1)'(1);
    last    = idx_inc >= {1'b0, len_n};
  end

  assign div_start = (state_q == ST_PREP) && env_div;

  // First pass scales amplitude by the shape, second pass by the envelope.
  always_comb begin
    mul_req.start = ((state_q == ST_WAIT_DIV) && (!env_div_q || div_done)) ||
                    ((state_q == ST_MUL_AW) && mul_done);
    if (state_q == ST_MUL_AW) begin
      mul_req.a = mul_prod[eto_pkg::MUL_A_W-1:0];
      mul_req.b = env_q;
    end else begin
      mul_req.a = eto_pkg::MUL_A_W'(amplitude_q);
      mul_req.b = eto_pkg::ENV_W'(shape.mag);
    end
  end

  always_comb begin
    mag_ext = MW'(mul_prod[eto_pkg::MUL_P_W-1:eto_pkg::MAG_SHIFT]);
    mag_sat = (mag_ext > MAG_LIM) ? MAG_LIM : mag_ext;
    res     = SAMPLE_BITS'(shape.neg ? (MW'(0) - mag_sat) : mag_sat);
  end

  eto_shape #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_shape (
    .clk_i        (clk_i),
    .load_i       (state_q == ST_PREP),
    .wave_shape_i (wave_shape_q),
    .phase_i      (phase_q),
    .shape_o      (shape)
  );

  eto_div #(
    .W (COUNT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  eto_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q    <= '0;
      phase_step_q    <= '0;
      amplitude_q     <= '0;
      note_length_q   <= eto_pkg::LEN_W'(1);
      attack_length_q <= '0;
      release_point_q <= '0;
    end else if (cfg_we_i) begin
      unique case (eto_pkg::cfg_idx_e'(cfg_idx_i))
        eto_pkg::CFG_WAVE_SHAPE:    wave_shape_q    <= cfg_data_i[eto_pkg::WAVE_SEL_W-1:0];
        eto_pkg::CFG_PHASE_STEP:    phase_step_q    <= cfg_data_i[eto_pkg::STEP_W-1:0];
        eto_pkg::CFG_AMPLITUDE:     amplitude_q     <= cfg_data_i[eto_pkg::AMP_W-1:0];
        eto_pkg::CFG_NOTE_LENGTH:   note_length_q   <= cfg_data_i[eto_pkg::LEN_W-1:0];
        eto_pkg::CFG_ATTACK_LENGTH: attack_length_q <= cfg_data_i[eto_pkg::LEN_W-1:0];
        eto_pkg::CFG_RELEASE_POINT: release_point_q <= cfg_data_i[eto_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      idx_q       <= '0;
      playing_q   <= 1'b0;
      env_div_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if ((state_q == ST_SEND) && out_free) begin
        out_valid_q <= 1'b1;
        sample_q    <= res;
        out_last_q  <= last_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (restart_i) begin
              phase_q   <= '0;
              idx_q     <= '0;
              playing_q <= 1'b1;
            end
            if (restart_i || playing_q) begin
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          // The shape stage samples the phase before this advance.
          phase_q   <= phase_q + PHASE_BITS'(phase_step_q);
          env_div_q <= env_div;
          if (last) begin
            playing_q <= 1'b0;
            idx_q     <= '0;
          end else begin
            idx_q <= idx_inc[COUNT_BITS-1:0];
          end
          state_q <= ST_WAIT_DIV;
        end
        ST_WAIT_DIV: begin
          if (!env_div_q || div_done) begin
            state_q <= ST_MUL_AW;
          end
        end
        ST_MUL_AW: begin
          if (mul_done) begin
            state_q <= ST_MUL_ENV;
          end
        end
        ST_MUL_ENV: begin
          if (mul_done) begin
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      env_q  <= env_fix;
      last_q <= last;
    end
    if ((state_q == ST_WAIT_DIV) && env_div_q && div_done) begin
      env_q <= {1'b0, div_quot};
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = out_last_q;

endmodule

// ===== tb/enveloped_tone_oscillator_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for enveloped_tone_oscillator_top: a queue-fed tick driver, a result
// monitor with random stalls, and a per-tick sample predictor. Depends on eto_pkg and the RTL.
module enveloped_tone_oscillator_top_test;

  localparam int          SAMPLE_W      = 16;
  localparam int          TBL_LOG       = 8;
  localparam int          TBL_D         = 1 << TBL_LOG;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned LEN_CAP   = 64'd1 << 20;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_TICKS  = 480;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } tone_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 restart_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic                 last_o;
  logic                 cfg_we_i   = 1'b0;
  logic [eto_pkg::CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [eto_pkg::CFG_W-1:0]     cfg_data_i = '0;

  // Register copies and note state of the predictor.
  eto_pkg::wave_e reg_wave = eto_pkg::WAVE_SINE;
  logic [31:0] reg_step    = '0;
  logic [14:0] reg_amp     = '0;
  logic [20:0] reg_len     = 21'd1;
  logic [20:0] reg_attack  = '0;
  logic [20:0] reg_release = '0;
  logic [31:0] tone_phase  = '0;
  logic [20:0] tone_index  = '0;
  bit          tone_on     = 1'b0;
  logic [15:0] quarter_sine [0:TBL_D];

  bit          tick_q [$];
  tone_t       sample_due_q [$];
  int unsigned ticks_planned  = 0;
  int unsigned mismatches     = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned quiet_cycles   = 0;
  bit          no_gaps        = 1'b0;
  bit          long_hold_req  = 1'b0;
  bit          long_hold_done = 1'b0;

  enveloped_tone_oscillator_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Quarter-wave table from a Q30 Taylor series, rounded to units of 1/32768.
  function automatic void fill_quarter_sine();
    longint unsigned k, n, a, sum, t, v;
    for (k = 0; k <= TBL_D; k++) begin
      a   = (k * QUARTER_TURN_Q30) >> TBL_LOG;
      sum = a;
      t   = a;
      for (n = 1; n <= 6; n++) begin
        t   = ((((t * a) >> 30) * a) >> 30) / ((2 * n) * (2 * n + 1));
        sum = (n % 2 == 1) ? sum - t : sum + t;
      end
      v = (sum + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      quarter_sine[k] = 16'(v);
    end
  endfunction

  // Shape value at phase p, in units of 1/32768.
  function automatic longint shape_at(input logic [31:0] p);
    logic [31:0] f;
    logic [31:0] span;
    longint      m;
    longint      s;
    case (reg_wave)
      eto_pkg::WAVE_SINE: begin
        m = p[30] ? quarter_sine[TBL_D - p[29:22]] : quarter_sine[p[29:22]];
        return p[31] ? -m : m;
      end
      eto_pkg::WAVE_SQUARE: begin
        if (p == 32'h0 || p == 32'h8000_0000) return 0;
        return p[31] ? -32768 : 32768;
      end
      eto_pkg::WAVE_TRIANGLE: begin
        f    = p - 32'h4000_0000;
        span = f[31] ? (32'd0 - f) : f;
        s    = longint'(span >> 15);
        return 32768 - s;
      end
      default: return longint'($signed(p[31:16]));
    endcase
  endfunction

  // Advances the note by one tick; returns 1 when the tick yields a sample.
  function automatic bit synth_sample(input bit restart, output tone_t res);
    longint unsigned len, rel, att, idx, env, num, den, aw, mag;
    longint          w;
    bit              is_last;
    res = '0;
    if (restart) begin
      tone_on    = 1'b1;
      tone_phase = '0;
      tone_index = '0;
    end
    if (!tone_on) return 1'b0;
    len = reg_len;
    if (len < 1) len = 1;
    if (len > LEN_CAP) len = LEN_CAP;
    rel = (reg_release < len) ? reg_release : len;
    att = (reg_attack < rel) ? reg_attack : rel;
    idx = tone_index;
    env = 64'd65536;
    if (idx < att) env = (idx << 16) / att;
    if (idx >= rel) begin
      // A note shortened under the index has no samples left to fall over.
      num = (len > idx) ? len - idx - 1 : 0;
      den = len - rel;
      env = (den != 0) ? (num << 16) / den : 0;
    end
    w   = shape_at(tone_phase);
    aw  = (w < 0) ? -w : w;
    mag = (longint'(reg_amp) * aw * env) >> 31;
    if (mag > 64'd32767) mag = 64'd32767;
    is_last    = (idx + 1 >= len);
    res.sample = (w < 0) ? 16'(64'd0 - mag) : 16'(mag);
    res.last   = is_last;
    tone_phase = tone_phase + reg_step;
    if (is_last) begin
      tone_on    = 1'b0;
      tone_index = '0;
    end else begin
      tone_index = 21'(idx + 1);
    end
    return 1'b1;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(input eto_pkg::cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      eto_pkg::CFG_WAVE_SHAPE:    reg_wave    = eto_pkg::wave_e'(val[1:0]);
      eto_pkg::CFG_PHASE_STEP:    reg_step    = val;
      eto_pkg::CFG_AMPLITUDE:     reg_amp     = val[14:0];
      eto_pkg::CFG_NOTE_LENGTH:   reg_len     = val[20:0];
      eto_pkg::CFG_ATTACK_LENGTH: reg_attack  = val[20:0];
      eto_pkg::CFG_RELEASE_POINT: reg_release = val[20:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every queued tick is transferred and every sample has arrived,
  // then leaves room for a tick that gave no sample to clear the block.
  task automatic settle();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || sample_due_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Appends one tick to the driver's queue.
  task automatic add_tick(input bit restart);
    tick_q = {tick_q, restart};
  endtask

  task automatic play_note(input int unsigned n);
    int unsigned j;
    add_tick(1'b1);
    for (j = 1; j < n; j++) add_tick(1'b0);
  endtask

  task automatic randomize_regs();
    int unsigned pick;
    logic [31:0] len;
    write_reg(eto_pkg::CFG_WAVE_SHAPE, $urandom_range(0, 3));
    pick = $urandom_range(0, 7);
    write_reg(eto_pkg::CFG_PHASE_STEP, (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
                              (pick < 4) ? $urandom_range(1, 32'h0800_0000) : $urandom);
    pick = $urandom_range(0, 5);
    write_reg(eto_pkg::CFG_AMPLITUDE, (pick == 0) ? 0 : (pick == 1) ? 32767 :
                                      $urandom_range(0, 32767));
    pick = $urandom_range(0, 11);
    len  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'(LEN_CAP) : (pick == 2) ? 32'h1F_FFFF :
           $urandom_range(1, 24);
    write_reg(eto_pkg::CFG_NOTE_LENGTH, len);
    write_reg(eto_pkg::CFG_ATTACK_LENGTH, ($urandom_range(0, 9) == 0) ? 32'h1F_FFFF :
                                 $urandom_range(0, len + 3));
    write_reg(eto_pkg::CFG_RELEASE_POINT, ($urandom_range(0, 9) == 0) ? 32'h1F_FFFF :
                                 $urandom_range(0, len + 3));
  endtask

  // Tick driver: predicts each transfer, then presents the next queued tick after a gap.
  always @(posedge clk_i) begin
    tone_t due;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (synth_sample(restart_i, due)) sample_due_q = {sample_due_q, due};
        gap_left = gap_len();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid_i <= 1'b1;
          restart_i  <= tick_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Sample monitor with random stalls and one long hold-off.
  always @(posedge clk_i) begin
    tone_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sample_due_q.size() == 0) begin
          $error("sample %0d, last %0b with nothing pending", sample_o, last_o);
          mismatches++;
        end else begin
          want = sample_due_q.pop_front();
          if (sample_o !== want.sample) begin
            $error("sample: expected %0d, got %0d", $signed(want.sample), sample_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            mismatches++;
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        stall_left     = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (stall_left == 0 && $urandom_range(0, 99) < 12) begin
        stall_left = gap_len();
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("enveloped_tone_oscillator_top_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned len_eff;
    int unsigned j;
    fill_quarter_sine();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Plain tick with no note, then a note under the reset settings.
    add_tick(1'b0);
    add_tick(1'b1);
    settle();
    // Sine at quarter-cycle steps, through rise, plateau and fall.
    write_reg(eto_pkg::CFG_WAVE_SHAPE, eto_pkg::WAVE_SINE);
    write_reg(eto_pkg::CFG_PHASE_STEP, 32'h4000_0000);
    write_reg(eto_pkg::CFG_AMPLITUDE, 32767);
    write_reg(eto_pkg::CFG_NOTE_LENGTH, 5);
    write_reg(eto_pkg::CFG_ATTACK_LENGTH, 2);
    write_reg(eto_pkg::CFG_RELEASE_POINT, 3);
    play_note(5);
    settle();
    // Square with a flat envelope lands on phase zero and one half.
    write_reg(eto_pkg::CFG_WAVE_SHAPE, eto_pkg::WAVE_SQUARE);
    write_reg(eto_pkg::CFG_ATTACK_LENGTH, 0);
    write_reg(eto_pkg::CFG_NOTE_LENGTH, 4);
    write_reg(eto_pkg::CFG_RELEASE_POINT, 4);
    play_note(4);
    settle();
    write_reg(eto_pkg::CFG_WAVE_SHAPE, eto_pkg::WAVE_TRIANGLE);
    write_reg(eto_pkg::CFG_PHASE_STEP, 32'h2000_0000);
    play_note(4);
    settle();
    write_reg(eto_pkg::CFG_WAVE_SHAPE, eto_pkg::WAVE_SAW);
    write_reg(eto_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
    play_note(3);
    settle();
    // Out-of-range lengths clamp; a restart drops the running note.
    write_reg(eto_pkg::CFG_NOTE_LENGTH, 32'h1F_FFFF);
    write_reg(eto_pkg::CFG_ATTACK_LENGTH, 32'h1F_FFFF);
    write_reg(eto_pkg::CFG_RELEASE_POINT, 32'h1F_FFFF);
    play_note(3);
    play_note(2);
    settle();
    // The note is shortened below its index: it ends at once with zero envelope.
    write_reg(eto_pkg::CFG_NOTE_LENGTH, 2);
    add_tick(1'b0);
    add_tick(1'b0);
    settle();
    write_reg(eto_pkg::CFG_NOTE_LENGTH, 0);
    add_tick(1'b1);

    phase_no = 0;
    while (ticks_planned < RANDOM_TICKS) begin
      settle();
      no_gaps = ($urandom_range(0, 3) == 0);
      randomize_regs();
      if (phase_no == 2) begin
        // Long note with the monitor held off, so the block backs up into the driver.
        write_reg(eto_pkg::CFG_NOTE_LENGTH, 40);
        no_gaps = 1'b1;
      end
      len_eff = (reg_len == '0) ? 1 :
                (64'(reg_len) > LEN_CAP) ? 32'(LEN_CAP) : 32'(reg_len);
      if (len_eff > 48) len_eff = 48;
      if (phase_no != 2 && $urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(10, 30)) begin
          add_tick(bit'($urandom_range(0, 2) == 0));
          ticks_planned++;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          add_tick(1'b1);
          ticks_planned++;
          for (j = 1; j < len_eff; j++) begin
            add_tick(bit'($urandom_range(0, 24) == 0));
            ticks_planned++;
          end
          if ($urandom_range(0, 3) == 0) add_tick(1'b0);
        end
      end
      if (phase_no == 2) long_hold_req = 1'b1;
      phase_no++;
    end

    settle();
    if (mismatches == 0) begin
      $display("enveloped_tone_oscillator_top_test: done, clean");
    end else begin
      $display("enveloped_tone_oscillator_top_test: done, errors");
    end
    $finish;
  end

endmodule
